>>> hdl/grid_diffusion_stencil_macros.svh
// Assertion macros for the grid diffusion stencil checker.
// Used by the checker file only; relies on a clock named clk in scope.
`ifndef GRID_DIFFUSION_STENCIL_MACROS_SVH
`define GRID_DIFFUSION_STENCIL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GDS_ASSERT_NOW(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("grid_diffusion_stencil check failed");

// Next-cycle implication, checked during reset as well.
`define GDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grid_diffusion_stencil check failed");

`endif

>>> hdl/gds_pkg.sv
// Shared types and constants for the grid diffusion stencil.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package gds_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int SHARE_W      = 16;
  localparam int COLS_CFG_W   = 9;
  localparam int ROWS_W       = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MIN_SIZE     = 2;
  localparam int MAX_ROWS     = 4096;
  localparam int RESET_SIZE   = 50;
  localparam int ONE_W        = SHARE_W + 1;
  localparam int PART_W       = SAMPLE_W + 2;
  localparam int SUM_W        = SAMPLE_W + 3;
  localparam int OWN_PROD_W   = ONE_W + SAMPLE_W;
  localparam int NEIGH_PROD_W = SHARE_W + SUM_W;
  localparam int NUM_W        = OWN_PROD_W + 4;
  localparam int RESULT_SHIFT = 19;
  localparam int LINE_W       = 2 * SAMPLE_W;

  localparam logic [ONE_W-1:0] ONE_Q16 = ONE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHARE   = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_ROWS    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } border_t;

endpackage

`default_nettype wire

>>> hdl/gds_line_buffer.sv
// Dual line buffer memory with registered read and write-through forwarding.
// Depends on nothing; instantiated once by the top level.
`default_nettype none

module gds_line_buffer #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                 rd_data,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/gds_sequencer.sv
// Raster position counters, border flags and the input register stage.
// Depends on gds_pkg.
`default_nettype none

module gds_sequencer #(
  parameter int MAX_COLUMNS = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      en,
  input  wire logic                                      take,
  input  wire logic [gds_pkg::SAMPLE_W-1:0]              sample,
  input  wire logic                                      pad,
  input  wire logic [gds_pkg::COLS_CFG_W-1:0]            grid_columns,
  input  wire logic [gds_pkg::ROWS_W-1:0]                grid_rows,
  output logic [$clog2(MAX_COLUMNS > 1 ? MAX_COLUMNS : 2)-1:0] rd_addr,
  output logic                                           s1_valid,
  output logic [$clog2(MAX_COLUMNS > 1 ? MAX_COLUMNS : 2)-1:0] s1_col,
  output logic [gds_pkg::SAMPLE_W-1:0]                   s1_sample,
  output gds_pkg::border_t                               s1_border
);

  localparam int ADDR_W = $clog2(MAX_COLUMNS > 1 ? MAX_COLUMNS : 2);
  localparam int FULL_W = $clog2(MAX_COLUMNS + 1);
  localparam int CNT_W  = (FULL_W > gds_pkg::COLS_CFG_W) ? FULL_W : gds_pkg::COLS_CFG_W;
  localparam int RW     = gds_pkg::ROWS_W;

  logic [ADDR_W-1:0] column_count, column_count_next;
  logic [RW-1:0]     row_count, row_count_next;

  logic [CNT_W-1:0]  cols, cols_cfg, ic_ext, ic_inc, cc;
  logic [RW-1:0]     rows, rows_p1, ir, cr;
  logic [ADDR_W-1:0] ic;
  logic              restart;
  gds_pkg::border_t  border;

  always_comb begin
    cols_cfg = CNT_W'(grid_columns);
    if (cols_cfg < CNT_W'(gds_pkg::MIN_SIZE)) begin
      cols = CNT_W'(gds_pkg::MIN_SIZE);
    end else if (cols_cfg > CNT_W'(MAX_COLUMNS)) begin
      cols = CNT_W'(MAX_COLUMNS);
    end else begin
      cols = cols_cfg;
    end

    if (grid_rows < RW'(gds_pkg::MIN_SIZE)) begin
      rows = RW'(gds_pkg::MIN_SIZE);
    end else if (grid_rows > RW'(gds_pkg::MAX_ROWS)) begin
      rows = RW'(gds_pkg::MAX_ROWS);
    end else begin
      rows = grid_rows;
    end
    rows_p1 = rows + RW'(1);

    restart = (CNT_W'(column_count) >= cols) || (row_count > rows_p1) ||
              ((row_count == rows_p1) && (column_count != '0));
    ic     = restart ? '0 : column_count;
    ir     = restart ? '0 : row_count;
    ic_ext = CNT_W'(ic);

    cr = '0;
    cc = '0;
    border = '0;
    if ((ic != '0) && (ir != '0)) begin
      cr = ir - RW'(1);
      cc = ic_ext - CNT_W'(1);
      border.emit = 1'b1;
    end else if ((ic == '0) && (ir >= RW'(2))) begin
      cr = ir - RW'(2);
      cc = cols - CNT_W'(1);
      border.emit = 1'b1;
    end
    border.has_up    = (cr != '0);
    border.has_down  = (cr < (rows - RW'(1)));
    border.has_left  = (cc != '0);
    border.has_right = (cc < (cols - CNT_W'(1)));
    border.last      = border.emit && (cr == (rows - RW'(1))) &&
                       (cc == (cols - CNT_W'(1)));

    ic_inc = ic_ext + CNT_W'(1);
    if (border.last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (ic_inc >= cols) begin
      column_count_next = '0;
      row_count_next    = ir + RW'(1);
    end else begin
      column_count_next = ic_inc[ADDR_W-1:0];
      row_count_next    = ir;
    end

    rd_addr = ic;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (take) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (en) begin
        s1_valid <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col    <= ic;
      s1_sample <= pad ? '0 : sample;
      s1_border <= border;
    end
  end

endmodule

`default_nettype wire

>>> hdl/gds_window.sv
// 3x3 window shift register and masked neighbor partial sums.
// Depends on gds_pkg; fed by the sequencer and the line buffer.
`default_nettype none

module gds_window (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             s1_valid,
  input  wire logic [gds_pkg::SAMPLE_W-1:0]     s1_sample,
  input  wire gds_pkg::border_t                 s1_border,
  input  wire logic [gds_pkg::LINE_W-1:0]       line_rd,
  output logic                                  line_wr_en,
  output logic [gds_pkg::LINE_W-1:0]            line_wr,
  output logic                                  s2_valid,
  output logic                                  s2_last,
  output logic [gds_pkg::SAMPLE_W-1:0]          s2_own,
  output logic [gds_pkg::PART_W-1:0]            s2_part_a,
  output logic [gds_pkg::PART_W-1:0]            s2_part_b
);

  localparam int SW = gds_pkg::SAMPLE_W;
  localparam int PW = gds_pkg::PART_W;

  logic [SW-1:0] win [9];
  logic [SW-1:0] nw [9];
  logic [SW-1:0] top, mid;
  logic [PW-1:0] part_a, part_b;
  logic          fire;

  always_comb begin
    top   = line_rd[gds_pkg::LINE_W-1:SW];
    mid   = line_rd[SW-1:0];
    fire  = en && s1_valid;
    nw[0] = win[1];
    nw[1] = win[2];
    nw[2] = top;
    nw[3] = win[4];
    nw[4] = win[5];
    nw[5] = mid;
    nw[6] = win[7];
    nw[7] = win[8];
    nw[8] = s1_sample;

    part_a = '0;
    part_b = '0;
    if (s1_border.has_up) begin
      part_a = PW'(nw[1]) + (s1_border.has_left ? PW'(nw[0]) : '0) +
               (s1_border.has_right ? PW'(nw[2]) : '0);
    end
    if (s1_border.has_left) begin
      part_a = part_a + PW'(nw[3]);
    end
    if (s1_border.has_down) begin
      part_b = PW'(nw[7]) + (s1_border.has_left ? PW'(nw[6]) : '0) +
               (s1_border.has_right ? PW'(nw[8]) : '0);
    end
    if (s1_border.has_right) begin
      part_b = part_b + PW'(nw[5]);
    end

    line_wr_en = fire;
    line_wr    = {mid, s1_sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_border.emit;
      if (s1_valid) begin
        for (int i = 0; i < 9; i++) begin
          win[i] <= nw[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_last   <= s1_border.last;
      s2_own    <= nw[4];
      s2_part_a <= part_a;
      s2_part_b <= part_b;
    end
  end

endmodule

`default_nettype wire

>>> hdl/gds_blend.sv
// Weighted blend of a cell with its neighbor sum, and the output register.
// Depends on gds_pkg; fed by the window stage.
`default_nettype none

module gds_blend (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic [gds_pkg::SHARE_W-1:0]      diffusion_share,
  input  wire logic                             s2_valid,
  input  wire logic                             s2_last,
  input  wire logic [gds_pkg::SAMPLE_W-1:0]     s2_own,
  input  wire logic [gds_pkg::PART_W-1:0]       s2_part_a,
  input  wire logic [gds_pkg::PART_W-1:0]       s2_part_b,
  output logic                                  out_valid,
  output logic [gds_pkg::SAMPLE_W-1:0]          diffused,
  output logic                                  frame_last
);

  localparam int SUM_W = gds_pkg::SUM_W;
  localparam int OPW   = gds_pkg::OWN_PROD_W;
  localparam int NPW   = gds_pkg::NEIGH_PROD_W;
  localparam int NW    = gds_pkg::NUM_W;

  logic            s3_valid, s3_last;
  logic [SUM_W-1:0] s3_sum;
  logic [OPW-1:0]  s3_own_prod;
  logic            s4_valid, s4_last;
  logic [NPW-1:0]  s4_neigh_prod;
  logic [OPW-1:0]  s4_own_prod;
  logic [gds_pkg::ONE_W-1:0] keep;
  logic [NW-1:0]   num;

  always_comb begin
    keep = gds_pkg::ONE_Q16 - gds_pkg::ONE_W'(diffusion_share);
    num  = NW'({s4_own_prod, 3'b000}) + NW'(s4_neigh_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_valid) begin
        s3_last     <= s2_last;
        s3_sum      <= SUM_W'(s2_part_a) + SUM_W'(s2_part_b);
        s3_own_prod <= OPW'(keep) * OPW'(s2_own);
      end
      if (s3_valid) begin
        s4_last       <= s3_last;
        s4_own_prod   <= s3_own_prod;
        s4_neigh_prod <= NPW'(diffusion_share) * NPW'(s3_sum);
      end
      if (s4_valid) begin
        frame_last <= s4_last;
        diffused   <= num[gds_pkg::RESULT_SHIFT +: gds_pkg::SAMPLE_W];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/grid_diffusion_stencil.sv
// Eight-neighbor diffusion stencil over a raster grid, one value per transfer.
// Each result passes the s1, s2, s3, s4 and output registers after the transfer
// that completes its window; one item can be taken every cycle, and the whole
// pipeline, input included, stalls while a result waits. Results trail the input
// by the clamped column count + 1 items. Reset clears the counters, window and
// pipeline and loads the default sizes; the line buffer memory is not cleared.
`default_nettype none

module grid_diffusion_stencil #(
  parameter int MAX_COLUMNS = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [gds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [gds_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                             pad,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [gds_pkg::SAMPLE_W-1:0]          diffused,
  output logic                                  frame_last
);

  localparam int ADDR_W = $clog2(MAX_COLUMNS > 1 ? MAX_COLUMNS : 2);

  logic [gds_pkg::SHARE_W-1:0]    diffusion_share;
  logic [gds_pkg::COLS_CFG_W-1:0] grid_columns;
  logic [gds_pkg::ROWS_W-1:0]     grid_rows;

  logic                          en, take;
  logic [ADDR_W-1:0]             rd_addr, s1_col;
  logic                          s1_valid;
  logic [gds_pkg::SAMPLE_W-1:0]  s1_sample;
  gds_pkg::border_t              s1_border;
  logic [gds_pkg::LINE_W-1:0]    line_rd, line_wr;
  logic                          line_wr_en;
  logic                          s2_valid, s2_last;
  logic [gds_pkg::SAMPLE_W-1:0]  s2_own;
  logic [gds_pkg::PART_W-1:0]    s2_part_a, s2_part_b;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign take     = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_share <= '0;
      grid_columns    <= gds_pkg::COLS_CFG_W'(gds_pkg::RESET_SIZE);
      grid_rows       <= gds_pkg::ROWS_W'(gds_pkg::RESET_SIZE);
    end else if (cfg_write) begin
      case (cfg_index)
        gds_pkg::REG_SHARE: begin
          diffusion_share <= cfg_data[gds_pkg::SHARE_W-1:0];
        end
        gds_pkg::REG_COLUMNS: begin
          grid_columns <= cfg_data[gds_pkg::COLS_CFG_W-1:0];
        end
        gds_pkg::REG_ROWS: begin
          grid_rows <= cfg_data[gds_pkg::ROWS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  gds_sequencer #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .take        (take),
    .sample      (sample),
    .pad         (pad),
    .grid_columns(grid_columns),
    .grid_rows   (grid_rows),
    .rd_addr     (rd_addr),
    .s1_valid    (s1_valid),
    .s1_col      (s1_col),
    .s1_sample   (s1_sample),
    .s1_border   (s1_border)
  );

  gds_line_buffer #(
    .DEPTH(MAX_COLUMNS),
    .WIDTH(gds_pkg::LINE_W)
  ) u_line_buffer (
    .clk    (clk),
    .rd_en  (take),
    .rd_addr(rd_addr),
    .rd_data(line_rd),
    .wr_en  (line_wr_en),
    .wr_addr(s1_col),
    .wr_data(line_wr)
  );

  gds_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample),
    .s1_border (s1_border),
    .line_rd   (line_rd),
    .line_wr_en(line_wr_en),
    .line_wr   (line_wr),
    .s2_valid  (s2_valid),
    .s2_last   (s2_last),
    .s2_own    (s2_own),
    .s2_part_a (s2_part_a),
    .s2_part_b (s2_part_b)
  );

  gds_blend u_blend (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .diffusion_share(diffusion_share),
    .s2_valid       (s2_valid),
    .s2_last        (s2_last),
    .s2_own         (s2_own),
    .s2_part_a      (s2_part_a),
    .s2_part_b      (s2_part_b),
    .out_valid      (out_valid),
    .diffused       (diffused),
    .frame_last     (frame_last)
  );

endmodule

`default_nettype wire

>>> hdl/gds_checker.sv
// Port-level checks for the grid diffusion stencil, bound to the top level.
// Depends on grid_diffusion_stencil_macros.svh and gds_pkg.
`default_nettype none
`include "grid_diffusion_stencil_macros.svh"

module gds_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [gds_pkg::SAMPLE_W-1:0] diffused,
  input wire logic                         frame_last
);

  logic [3:0] quiet_hist;
  logic [3:0] in_hist;
  logic       settled;
  logic       waiting;

  // The pipeline never stalled over the cycles held in quiet_hist and nothing entered it
  // early enough to reach the output by the next cycle.
  always_ff @(posedge clk) begin
    quiet_hist <= {quiet_hist[2:0], !rst && !out_valid};
    in_hist    <= {in_hist[2:0], in_valid};
  end

  assign settled = !rst && !out_valid && (&quiet_hist) && !in_hist[3];
  assign waiting = out_valid && !out_ready && !rst;

  `GDS_ASSERT_NEXT(a_reset_empty, rst, !out_valid)
  `GDS_ASSERT_NOW(a_ready_when_empty, rst, !out_valid, in_ready)
  `GDS_ASSERT_NOW(a_ready_when_drained, rst, out_ready, in_ready)
  `GDS_ASSERT_NEXT(a_result_held, waiting, out_valid && $stable(diffused) && $stable(frame_last))
  `GDS_ASSERT_NEXT(a_no_result_from_idle, settled, !out_valid)

endmodule

bind grid_diffusion_stencil gds_checker u_gds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .diffused  (diffused),
  .frame_last(frame_last)
);

`default_nettype wire

>>> test/grid_diffusion_stencil_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_diffusion_stencil: raster frames are sent over
// valid/ready while a behavioral copy of the stencil predicts every diffused cell.
// Depends on gds_pkg and the block's RTL only.
module grid_diffusion_stencil_test;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  localparam int LINE_DEPTH = 256;
  localparam int DRAIN_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 240;
  localparam logic [gds_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [gds_pkg::SAMPLE_W-1:0] FULL_SCALE = '1;

  typedef struct packed {
    logic [gds_pkg::SAMPLE_W-1:0] value;
    logic is_pad;
  } grid_item_t;

  typedef struct packed {
    logic [gds_pkg::SAMPLE_W-1:0] value;
    logic last;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [gds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [gds_pkg::SAMPLE_W-1:0] sample = '0;
  logic pad = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gds_pkg::SAMPLE_W-1:0] diffused;
  logic frame_last;

  logic [gds_pkg::SAMPLE_W-1:0] upper_row [LINE_DEPTH];
  logic [gds_pkg::SAMPLE_W-1:0] middle_row [LINE_DEPTH];
  logic [gds_pkg::SAMPLE_W-1:0] stencil [9];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [gds_pkg::SHARE_W-1:0] share_q16;
  logic [gds_pkg::COLS_CFG_W-1:0] columns_word;
  logic [gds_pkg::ROWS_W-1:0] rows_word;

  grid_item_t pending_cells[$];
  cell_result_t expected_cells[$];

  int mismatches = 0;
  int items_accepted = 0;
  int cells_checked = 0;
  int frames_closed = 0;
  int items_queued = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit hold_wanted = 1'b0;
  bit hold_served = 1'b0;
  bit in_fire = 1'b0;

  grid_diffusion_stencil #(.MAX_COLUMNS(LINE_DEPTH)) dut (.*);

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic int unsigned eff_columns();
    if (columns_word < gds_pkg::MIN_SIZE) return gds_pkg::MIN_SIZE;
    if (columns_word > LINE_DEPTH) return LINE_DEPTH;
    return 32'(columns_word);
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_word < gds_pkg::MIN_SIZE) return gds_pkg::MIN_SIZE;
    if (rows_word > gds_pkg::MAX_ROWS) return gds_pkg::MAX_ROWS;
    return 32'(rows_word);
  endfunction

  task automatic diffuse_cell(input logic [gds_pkg::SAMPLE_W-1:0] raw, input logic is_pad);
    int unsigned cols, rows, ic, ir, cr, cc;
    int k;
    logic [gds_pkg::SAMPLE_W-1:0] v, top, mid;
    logic emit, up, down, left, right;
    logic [63:0] sum, num;
    cell_result_t r;
    cols = eff_columns();
    rows = eff_rows();
    // A position outside the current frame abandons it.
    if (col_pos >= cols || row_pos > rows + 1 || (row_pos == rows + 1 && col_pos != 0)) begin
      col_pos = 0;
      row_pos = 0;
    end
    v = is_pad ? '0 : raw;
    ic = col_pos;
    ir = row_pos;
    top = upper_row[ic];
    mid = middle_row[ic];
    upper_row[ic] = mid;
    middle_row[ic] = v;
    for (k = 0; k < 3; k++) begin
      stencil[3*k] = stencil[3*k+1];
      stencil[3*k+1] = stencil[3*k+2];
    end
    stencil[2] = top;
    stencil[5] = mid;
    stencil[8] = v;
    emit = 1'b0;
    cr = 0;
    cc = 0;
    if (ic >= 1 && ir >= 1) begin
      cr = ir - 1;
      cc = ic - 1;
      emit = 1'b1;
    end else if (ic == 0 && ir >= 2) begin
      cr = ir - 2;
      cc = cols - 1;
      emit = 1'b1;
    end
    if (emit) begin
      up = cr > 0;
      down = cr < rows - 1;
      left = cc > 0;
      right = cc < cols - 1;
      sum = '0;
      if (up) begin
        sum += stencil[1];
        if (left) sum += stencil[0];
        if (right) sum += stencil[2];
      end
      if (down) begin
        sum += stencil[7];
        if (left) sum += stencil[6];
        if (right) sum += stencil[8];
      end
      if (left) sum += stencil[3];
      if (right) sum += stencil[5];
      num = (64'd65536 - 64'(share_q16)) * 64'd8 * 64'(stencil[4]) + 64'(share_q16) * sum;
      r.value = num[gds_pkg::RESULT_SHIFT +: gds_pkg::SAMPLE_W];
      r.last = (cr == rows - 1) && (cc == cols - 1);
      expected_cells.push_back(r);
      if (r.last) begin
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end
    ic++;
    if (ic >= cols) begin
      ic = 0;
      ir++;
    end
    col_pos = ic;
    row_pos = ir & 32'h1FFF;
  endtask

  always @(negedge clk) begin : drive_inputs
    grid_item_t next_item;
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_cells.pop_front();
        in_valid <= 1'b1;
        sample <= next_item.value;
        pad <= next_item.is_pad;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_wanted && !hold_served) begin
      hold_served <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    cell_result_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      diffuse_cell(sample, pad);
      items_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, actual diffused=%h frame_last=%b",
                 $time, diffused, frame_last);
      end else begin
        want = expected_cells.pop_front();
        if (want.value !== diffused) begin
          mismatches++;
          $display("%0t: diffused expected %h actual %h", $time, want.value, diffused);
        end
        if (want.last !== frame_last) begin
          mismatches++;
          $display("%0t: frame_last expected %b actual %b", $time, want.last, frame_last);
        end
        cells_checked++;
        if (frame_last) frames_closed++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [gds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gds_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      gds_pkg::REG_SHARE: share_q16 = data;
      gds_pkg::REG_COLUMNS: columns_word = data[gds_pkg::COLS_CFG_W-1:0];
      gds_pkg::REG_ROWS: rows_word = data[gds_pkg::ROWS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned share, input int unsigned cols,
                               input int unsigned rows);
    logic [gds_pkg::CFG_DATA_W-1:0] cols_data, rows_data, noise;
    cols_data = gds_pkg::CFG_DATA_W'(cols);
    rows_data = gds_pkg::CFG_DATA_W'(rows);
    if ($urandom_range(0, 3) == 0) begin
      noise = gds_pkg::CFG_DATA_W'($urandom);
      cols_data[gds_pkg::CFG_DATA_W-1:gds_pkg::COLS_CFG_W] =
        noise[gds_pkg::CFG_DATA_W-1:gds_pkg::COLS_CFG_W];
      noise = gds_pkg::CFG_DATA_W'($urandom);
      rows_data[gds_pkg::CFG_DATA_W-1:gds_pkg::ROWS_W] =
        noise[gds_pkg::CFG_DATA_W-1:gds_pkg::ROWS_W];
    end
    write_reg(gds_pkg::REG_SHARE, gds_pkg::CFG_DATA_W'(share));
    write_reg(gds_pkg::REG_COLUMNS, cols_data);
    write_reg(gds_pkg::REG_ROWS, rows_data);
  endtask

  task automatic wait_idle();
    while (pending_cells.size() != 0 || in_valid || expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_cell(input logic [gds_pkg::SAMPLE_W-1:0] value, input logic is_pad);
    grid_item_t it;
    it.value = value;
    it.is_pad = is_pad;
    pending_cells.push_back(it);
    items_queued++;
  endtask

  function automatic logic [gds_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return FULL_SCALE - gds_pkg::SAMPLE_W'($urandom_range(0, 3));
      3, 4: return gds_pkg::SAMPLE_W'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_frame(input int pad_pct, input bit noisy_flush);
    int unsigned cols, rows, n;
    cols = eff_columns();
    rows = eff_rows();
    for (n = 0; n < rows * cols; n++) push_cell(pick_sample(), $urandom_range(0, 99) < pad_pct);
    for (n = 0; n <= cols; n++) begin
      push_cell(pick_sample(), noisy_flush ? 1'($urandom_range(0, 1)) : 1'b1);
    end
  endtask

  task automatic random_setting();
    int unsigned share, cols, rows;
    case ($urandom_range(0, 7))
      0: share = 0;
      1: share = 65535;
      2: share = $urandom_range(1, 16);
      default: share = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 9))
      0: cols = $urandom_range(0, 1);
      1: cols = $urandom_range(13, 40);
      default: cols = $urandom_range(2, 12);
    endcase
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
    apply_setting(share, cols, rows);
  endtask

  task automatic random_frames(input int target);
    int mark;
    mark = items_queued;
    while (items_queued - mark < target) begin
      random_setting();
      repeat ($urandom_range(1, 3)) queue_frame(($urandom_range(0, 3) == 0) ? 10 : 0,
                                                 1'($urandom_range(0, 1)));
      wait_idle();
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < LINE_DEPTH; k++) begin
      upper_row[k] = '0;
      middle_row[k] = '0;
    end
    for (k = 0; k < 9; k++) stencil[k] = '0;
    col_pos = 0;
    row_pos = 0;
    share_q16 = '0;
    columns_word = gds_pkg::COLS_CFG_W'(gds_pkg::RESET_SIZE);
    rows_word = gds_pkg::ROWS_W'(gds_pkg::RESET_SIZE);
    send_idle_pct = 15;
    stall_pct = 88;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_setting(65535, 2, 2);
    push_cell(FULL_SCALE, 1'b0);
    push_cell('0, 1'b0);
    push_cell(FULL_SCALE, 1'b0);
    push_cell('0, 1'b0);
    repeat (3) push_cell('0, 1'b1);
    wait_idle();

    // The spare index must leave every register alone.
    write_reg(REG_SPARE, '1);
    apply_setting(32768, 3, 3);
    push_cell(FULL_SCALE, 1'b0);
    push_cell(32'h0000_0001, 1'b0);
    push_cell(32'h0000_1000, 1'b0);
    push_cell(FULL_SCALE, 1'b1);
    push_cell(FULL_SCALE, 1'b0);
    push_cell(32'h8000_0000, 1'b0);
    push_cell('0, 1'b0);
    push_cell(FULL_SCALE, 1'b0);
    push_cell(32'h7FFF_FFFF, 1'b0);
    push_cell(FULL_SCALE, 1'b0);
    push_cell(32'h5555_AAAA, 1'b0);
    push_cell(FULL_SCALE, 1'b1);
    push_cell('0, 1'b1);
    wait_idle();

    // Leave a frame unfinished, then shrink the rows so it is abandoned.
    apply_setting($urandom_range(0, 65535), 4, 10);
    repeat (30) push_cell(pick_sample(), 1'b0);
    wait_idle();
    apply_setting($urandom_range(0, 65535), 4, 2);
    queue_frame(0, 1'b1);
    wait_idle();

    random_frames(PHASE_ITEMS);

    send_idle_pct = 88;
    stall_pct = 15;
    apply_setting($urandom_range(0, 65535), 511, 2);
    queue_frame(0, 1'b1);
    wait_idle();
    random_frames(PHASE_ITEMS);

    send_idle_pct = 0;
    stall_pct = 0;
    apply_setting($urandom_range(0, 65535), 16, 20);
    queue_frame(2, 1'b0);
    hold_wanted = 1'b1;
    wait_idle();
    // A partial frame on the clamped sizes is abandoned by the next setting.
    apply_setting($urandom_range(0, 65535), 0, 8191);
    repeat (40) push_cell(pick_sample(), 1'b0);
    wait_idle();
    random_frames(PHASE_ITEMS);

    wait_idle();
    $display("Checked %0d diffused cells in %0d complete frames from %0d accepted items.",
             cells_checked, frames_closed, items_accepted);
    $display("Grids ran from 2x2 to the clamped 256-column width, with padded and abandoned frames.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
